// ===== rtl/bpa_pkg.sv =====
// Shared constants, types and helpers of the bitmap page allocator.
package bpa_pkg;

   localparam int MAX_WORDS = 1024;
   localparam int WORD_W    = 64;
   localparam int BIT_W     = 6;
   localparam int ADDR_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int CNT_W     = $clog2(MAX_WORDS + 1);
   localparam int BASE_W    = 24;
   localparam int WORDS_W   = 11;
   localparam int PAGE_W    = 32;
   localparam int CSR_W     = 32;
   localparam int PADDR_W   = 3;

   localparam logic [BASE_W-1:0]  BASE_RESET  = BASE_W'(2);
   localparam logic [WORDS_W-1:0] WORDS_RESET = WORDS_W'(1024);

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NOMEM   = 2'd1,
      STAT_INVALID = 2'd2,
      STAT_DOUBLE  = 2'd3
   } bpa_status_type;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } bpa_op_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_ALLOC_CHK,
      S_REL_CHK,
      S_FINISH
   } bpa_state_type;

   typedef enum logic {
      CSR_BASE_PAGE    = 1'b0,
      CSR_WORDS_IN_USE = 1'b1
   } bpa_csr_type;

   // controller to datapath
   typedef struct packed {
      logic           load_req;
      logic           alloc_start;
      logic           rel_start;
      logic           scan_step;
      logic           clr_write;
      logic           alloc_write;
      logic           rel_write;
      logic           respond;
      bpa_status_type resp_status;
   } bpa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_release;
      logic no_words;
      logic rel_invalid;
      logic word_full;
      logic scan_last;
      logic bit_set;
      logic clr_last;
   } bpa_stat_type;

   function automatic logic [BIT_W-1:0] bpa_bit_index(input logic [WORD_W-1:0] onehot);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (onehot[i]) begin
            idx = idx | BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== rtl/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bpa_dp.sv =====
// Datapath: request registers, hint, scan counters, bitmap RAM and result registers.
module bpa_dp import bpa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  bpa_cmd_type         cmd,
   output bpa_stat_type        stat,
   input  logic                req_cmd,
   input  logic [PAGE_W-1:0]   req_page_number,
   input  logic [BASE_W-1:0]   cfg_base_page,
   input  logic [WORDS_W-1:0]  cfg_words_in_use,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [PAGE_W-1:0]   rsp_page_number_res
);

   bpa_op_type          cmd_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [ADDR_W-1:0]   w_ff;
   logic [CNT_W-1:0]    tried_ff;
   logic [BIT_W-1:0]    bit_ff;
   logic [ADDR_W-1:0]   hint_ff;
   logic [ADDR_W-1:0]   clr_ff;
   logic                rsp_valid_ff;
   bpa_status_type      rsp_status_ff;
   logic [PAGE_W-1:0]   rsp_page_ff;

   logic [CNT_W-1:0]    live_words;
   logic [ADDR_W-1:0]   start_word;
   logic [PAGE_W-1:0]   base_ext;
   logic [PAGE_W-1:0]   rel_off;
   logic                rel_below;
   logic                rel_beyond;
   logic [CNT_W-1:0]    w_inc;
   logic [ADDR_W-1:0]   w_next;
   logic [CNT_W-1:0]    tried_inc;
   logic [WORD_W-1:0]   rd_data;
   logic [WORD_W-1:0]   rd_inc;
   logic [WORD_W-1:0]   set_word;
   logic [WORD_W-1:0]   low_mask;
   logic [WORD_W-1:0]   rel_mask;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [WORD_W-1:0]   wr_data;
   logic [ADDR_W-1:0]   rd_addr;

   assign live_words = (32'(cfg_words_in_use) > 32'(MAX_WORDS)) ? CNT_W'(MAX_WORDS)
                                                                : CNT_W'(cfg_words_in_use);
   assign start_word = (CNT_W'(hint_ff) < live_words) ? hint_ff : '0;

   assign base_ext   = PAGE_W'(cfg_base_page);
   assign rel_below  = page_ff < base_ext;
   assign rel_off    = page_ff - base_ext;
   assign rel_beyond = rel_off[PAGE_W-1:BIT_W] >= (PAGE_W - BIT_W)'(live_words);

   assign w_inc      = CNT_W'(w_ff) + CNT_W'(1);
   assign w_next     = (w_inc >= live_words) ? '0 : w_inc[ADDR_W-1:0];
   assign tried_inc  = tried_ff + CNT_W'(1);

   assign rd_inc     = rd_data + WORD_W'(1);
   assign set_word   = rd_data | rd_inc;
   assign low_mask   = ~rd_data & rd_inc;
   assign rel_mask   = WORD_W'(1) << bit_ff;

   assign stat.is_release  = (cmd_ff == CMD_RELEASE);
   assign stat.no_words    = (live_words == '0);
   assign stat.rel_invalid = rel_below | rel_beyond;
   assign stat.word_full   = &rd_data;
   assign stat.scan_last   = (tried_inc >= live_words);
   assign stat.bit_set     = |(rd_data & rel_mask);
   assign stat.clr_last    = (clr_ff == ADDR_W'(MAX_WORDS - 1));

   always_comb begin
      if (cmd.alloc_start) begin
         rd_addr = start_word;
      end else if (cmd.rel_start) begin
         rd_addr = rel_off[BIT_W+ADDR_W-1:BIT_W];
      end else if (cmd.scan_step) begin
         rd_addr = w_next;
      end else begin
         rd_addr = w_ff;
      end
   end

   always_comb begin
      wr_en   = cmd.clr_write | cmd.alloc_write | cmd.rel_write;
      wr_addr = cmd.clr_write ? clr_ff : w_ff;
      if (cmd.clr_write) begin
         wr_data = '0;
      end else if (cmd.alloc_write) begin
         wr_data = set_word;
      end else begin
         wr_data = rd_data & ~rel_mask;
      end
   end

   bpa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff  <= bpa_op_type'(req_cmd);
         page_ff <= req_page_number;
      end
      if (cmd.alloc_start) begin
         w_ff     <= start_word;
         tried_ff <= '0;
      end else if (cmd.rel_start) begin
         w_ff   <= rel_off[BIT_W+ADDR_W-1:BIT_W];
         bit_ff <= rel_off[BIT_W-1:0];
      end else if (cmd.scan_step) begin
         w_ff     <= w_next;
         tried_ff <= tried_inc;
      end else if (cmd.alloc_write) begin
         bit_ff <= bpa_bit_index(low_mask);
      end
      if (cmd.respond) begin
         rsp_status_ff <= cmd.resp_status;
         if (cmd.resp_status == STAT_OK && cmd_ff == CMD_ALLOC) begin
            rsp_page_ff <= base_ext + PAGE_W'({w_ff, bit_ff});
         end else begin
            rsp_page_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hint_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
         if (cmd.clr_write) begin
            clr_ff <= stat.clr_last ? '0 : clr_ff + ADDR_W'(1);
         end
         if (cmd.alloc_write || cmd.rel_write) begin
            hint_ff <= w_ff;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_page_number_res = rsp_page_ff;

   a_page_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_page_ff != '0) |-> rsp_status_ff == STAT_OK)
      else $error("nonzero page returned with failing status");

   a_scan_within_lap: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> tried_inc < live_words)
      else $error("scan ran past one lap");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc_write || cmd.rel_write) |-> CNT_W'(w_ff) < live_words)
      else $error("bitmap update outside words in use");

endmodule

// ===== rtl/bpa_ctrl.sv =====
// Controller: clearing pass, request decode, bitmap scan and release sequencing.
module bpa_ctrl import bpa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  bpa_stat_type  stat,
   output bpa_cmd_type   cmd
);

   bpa_state_type state_ff;
   bpa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.resp_status = STAT_OK;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!stat.is_release) begin
               if (stat.no_words) begin
                  cmd.respond     = 1'b1;
                  cmd.resp_status = STAT_NOMEM;
                  state_in        = S_IDLE;
               end else begin
                  cmd.alloc_start = 1'b1;
                  state_in        = S_ALLOC_CHK;
               end
            end else begin
               if (stat.rel_invalid) begin
                  cmd.respond     = 1'b1;
                  cmd.resp_status = STAT_INVALID;
                  state_in        = S_IDLE;
               end else begin
                  cmd.rel_start = 1'b1;
                  state_in      = S_REL_CHK;
               end
            end
         end
         S_ALLOC_CHK: begin
            if (!stat.word_full) begin
               cmd.alloc_write = 1'b1;
               state_in        = S_FINISH;
            end else if (stat.scan_last) begin
               cmd.respond     = 1'b1;
               cmd.resp_status = STAT_NOMEM;
               state_in        = S_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_REL_CHK: begin
            cmd.respond = 1'b1;
            if (stat.bit_set) begin
               cmd.rel_write   = 1'b1;
               cmd.resp_status = STAT_OK;
            end else begin
               cmd.resp_status = STAT_DOUBLE;
            end
            state_in = S_IDLE;
         end
         S_FINISH: begin
            cmd.respond     = 1'b1;
            cmd.resp_status = STAT_OK;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   a_respond_ends_item: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> state_ff == S_IDLE)
      else $error("response issued without returning to idle");

   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_write, cmd.alloc_write, cmd.rel_write}))
      else $error("conflicting bitmap writes");

endmodule

// ===== rtl/bitmap_page_allocator.sv =====
// Top level of the bitmap page allocator: register port, controller and datapath.
//
//  channel  ports                               transfer when
//  request  start, busy, req_*                  start && !busy
//  result   rsp_valid, rsp_*                    rsp_valid (one cycle, no backpressure)
//  csr      psel, penable, pwrite, paddr, ...   psel && penable && pwrite && pready
//
// Allocate: reads the start word and, while it is full, steps to the next word in use
// (one bitmap RAM read per cycle) until a clear bit is found; out of memory once every
// word in use has been tried. Release: read-modify-write of one word; an invalid page
// is rejected at decode. The result shows the cycle after the item completes.
// After reset a clearing pass writes all 1024 bitmap words with busy high.
// Results cannot be stalled by the receiver.
module bitmap_page_allocator import bpa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_cmd,
   input  logic [PAGE_W-1:0]   req_page_number,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [PAGE_W-1:0]   rsp_page_number_res,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [CSR_W-1:0]    pwdata,
   output logic [CSR_W-1:0]    prdata,
   output logic                pready
);

   logic [BASE_W-1:0]  base_page_ff;
   logic [WORDS_W-1:0] words_in_use_ff;
   logic               csr_write;
   bpa_csr_type        csr_sel;
   bpa_cmd_type        cmd;
   bpa_stat_type       stat;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_sel   = bpa_csr_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_page_ff    <= BASE_RESET;
         words_in_use_ff <= WORDS_RESET;
      end else if (csr_write) begin
         case (csr_sel)
            CSR_BASE_PAGE:    base_page_ff    <= pwdata[BASE_W-1:0];
            CSR_WORDS_IN_USE: words_in_use_ff <= pwdata[WORDS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_BASE_PAGE:    prdata = CSR_W'(base_page_ff);
         CSR_WORDS_IN_USE: prdata = CSR_W'(words_in_use_ff);
         default:          prdata = '0;
      endcase
   end

   bpa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bpa_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_cmd             (req_cmd),
      .req_page_number     (req_page_number),
      .cfg_base_page       (base_page_ff),
      .cfg_words_in_use    (words_in_use_ff),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_page_number_res (rsp_page_number_res)
   );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the bitmap page allocator: directed, exhaustion and random traffic.
module tb;
   import bpa_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 6;
   localparam int STALL_LIMIT  = 8000;
   localparam int RAND_PHASES  = 12;
   localparam int PHASE_ITEMS  = 70;

   typedef struct packed {
      bpa_status_type    status;
      logic [PAGE_W-1:0] page;
   } page_reply_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_cmd;
   logic [PAGE_W-1:0]  req_page_number;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [PAGE_W-1:0]  rsp_page_number_res;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [CSR_W-1:0]   pwdata;
   logic [CSR_W-1:0]   prdata;
   logic               pready;

   // allocator state as the testbench sees it
   logic [WORD_W-1:0]  used_map [MAX_WORDS];
   int unsigned        hint_idx;
   logic [BASE_W-1:0]  base_cfg;
   logic [WORDS_W-1:0] words_cfg;

   page_reply_type     pending_replies [$];
   page_reply_type     want_reply;
   int                 fail_count = 0;
   int                 sent_count = 0;
   int                 reply_count = 0;
   int                 status_count [4] = '{0, 0, 0, 0};
   int                 gap_max = 7;
   int                 stall_cycles = 0;

   bitmap_page_allocator u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_page_number     (req_page_number),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_page_number_res (rsp_page_number_res),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   function automatic int unsigned live_words();
      return (words_cfg > MAX_WORDS) ? MAX_WORDS : int'(words_cfg);
   endfunction

   // next-fit allocate / release, updates the bitmap and hint
   function automatic page_reply_type apply_request(input bpa_op_type op,
                                                    input logic [PAGE_W-1:0] page);
      page_reply_type    res;
      int unsigned       n;
      int unsigned       w;
      int unsigned       b;
      logic [PAGE_W-1:0] off;
      res.status = STAT_OK;
      res.page   = '0;
      n = live_words();
      if (op == CMD_ALLOC) begin
         res.status = STAT_NOMEM;
         w = (hint_idx < n) ? hint_idx : 0;
         for (int tried = 0; tried < n; tried++) begin
            if (used_map[w] != '1) begin
               b = 0;
               while (used_map[w][b]) b++;
               used_map[w][b] = 1'b1;
               hint_idx   = w;
               res.status = STAT_OK;
               res.page   = PAGE_W'(base_cfg) + PAGE_W'(w * WORD_W + b);
               break;
            end
            w = (w + 1 >= n) ? 0 : w + 1;
         end
      end else if (page < PAGE_W'(base_cfg)) begin
         res.status = STAT_INVALID;
      end else begin
         off = page - PAGE_W'(base_cfg);
         w   = off >> BIT_W;
         b   = off[BIT_W-1:0];
         if (w >= n) begin
            res.status = STAT_INVALID;
         end else if (!used_map[w][b]) begin
            res.status = STAT_DOUBLE;
         end else begin
            used_map[w][b] = 1'b0;
            hint_idx = w;
         end
      end
      return res;
   endfunction

   // a page marked in use, searched near the hint first; else a random page in range
   function automatic logic [PAGE_W-1:0] pick_used_page();
      int unsigned n;
      int unsigned w;
      int unsigned b;
      n = live_words();
      if (n == 0) return $urandom();
      for (int tries = 0; tries < 16; tries++) begin
         w = (tries < 8) ? (hint_idx + $urandom_range(0, 2)) % n : $urandom_range(0, n - 1);
         if (used_map[w] != '0) begin
            do b = $urandom_range(0, WORD_W - 1); while (!used_map[w][b]);
            return PAGE_W'(base_cfg) + PAGE_W'(w * WORD_W + b);
         end
      end
      return PAGE_W'(base_cfg) + PAGE_W'($urandom_range(0, n * WORD_W - 1));
   endfunction

   task automatic send_request(input bpa_op_type op, input logic [PAGE_W-1:0] page);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_cmd         <= op;
      req_page_number <= page;
      do @(posedge clock); while (busy !== 1'b0);
      pending_replies.push_back(apply_request(op, page));
      sent_count++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input bpa_csr_type idx, input logic [CSR_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         CSR_BASE_PAGE:    base_cfg  = value[BASE_W-1:0];
         CSR_WORDS_IN_USE: words_cfg = value[WORDS_W-1:0];
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic set_layout(input logic [BASE_W-1:0] base, input logic [WORDS_W-1:0] words);
      wait_idle();
      write_register(CSR_BASE_PAGE, CSR_W'(base));
      write_register(CSR_WORDS_IN_USE, CSR_W'(words));
   endtask

   task automatic test_directed_cases();
      send_request(CMD_ALLOC, '0);
      send_request(CMD_ALLOC, 32'h5555_5555);
      send_request(CMD_RELEASE, 32'd2);
      send_request(CMD_RELEASE, 32'd2);                    // double free
      send_request(CMD_RELEASE, 32'd0);                    // below base
      send_request(CMD_RELEASE, 32'd1);
      send_request(CMD_RELEASE, 32'hFFFF_FFFF);            // far beyond range
      send_request(CMD_RELEASE, 32'd2 + 32'd65536);        // first page past last word
      send_request(CMD_RELEASE, 32'd2 + 32'd65535);        // last bit of last word
      send_request(CMD_ALLOC, 32'hFFFF_FFFF);
      // no words in use
      set_layout(24'd0, 11'd0);
      send_request(CMD_ALLOC, 32'hAAAA_AAAA);
      send_request(CMD_RELEASE, 32'd0);
      // word count above the bitmap size saturates
      set_layout(24'd0, 11'd2047);
      send_request(CMD_RELEASE, 32'd65535);
      send_request(CMD_RELEASE, 32'd65536);
      send_request(CMD_ALLOC, '0);
      set_layout(24'hFF_FFFF, 11'd1024);
      send_request(CMD_ALLOC, '0);
      send_request(CMD_RELEASE, 32'h00FF_FFFF);
      send_request(CMD_RELEASE, 32'h00FF_FFFE);
      send_request(CMD_RELEASE, 32'h00FF_FFFF + 32'd65535);
      set_layout(24'd1, 11'd1);
      send_request(CMD_RELEASE, 32'd1);
      send_request(CMD_ALLOC, '0);
   endtask

   task automatic test_exhaustion();
      gap_max = 3;
      set_layout(24'd100, 11'd1);
      repeat (66) send_request(CMD_ALLOC, $urandom());
      send_request(CMD_RELEASE, 32'd163);
      send_request(CMD_ALLOC, $urandom());
      send_request(CMD_ALLOC, $urandom());
      set_layout(24'd100, 11'd3);
      repeat (66) send_request(CMD_ALLOC, $urandom());
      // hint now past the lowered word count, scan restarts at word zero
      set_layout(24'd100, 11'd2);
      send_request(CMD_ALLOC, $urandom());
      send_request(CMD_RELEASE, 32'd105);
      send_request(CMD_ALLOC, $urandom());
      set_layout(24'd100, 11'd3);
      send_request(CMD_RELEASE, 32'd228);
      set_layout(24'd100, 11'd1);
      send_request(CMD_ALLOC, $urandom());
      send_request(CMD_RELEASE, 32'd140);
      send_request(CMD_ALLOC, $urandom());
   endtask

   task automatic test_random_traffic();
      int unsigned       alloc_pct;
      int unsigned       roll;
      int unsigned       n;
      logic [BASE_W-1:0] base;
      logic [WORDS_W-1:0] words;
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         case ($urandom_range(0, 7))
            0:       words = 11'd1;
            1:       words = 11'd2;
            2:       words = WORDS_W'($urandom_range(3, 8));
            3:       words = WORDS_W'($urandom_range(1, 64));
            4:       words = 11'd1024;
            5:       words = WORDS_W'($urandom_range(1025, 2047));
            6:       words = WORDS_W'($urandom_range(1, 2047));
            default: words = WORDS_W'($urandom_range(2, 4));
         endcase
         case ($urandom_range(0, 4))
            0:       base = BASE_RESET;
            1:       base = '0;
            2:       base = 24'hFF_FFFF;
            3:       base = BASE_W'($urandom_range(0, 24'hFF_FFFF));
            default: base = BASE_W'($urandom_range(2, 1000));
         endcase
         set_layout(base, words);
         alloc_pct = $urandom_range(35, 90);
         gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 7;
         n = live_words();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct) begin
               send_request(CMD_ALLOC, $urandom());
            end else if (roll < 92) begin
               send_request(CMD_RELEASE, pick_used_page());
            end else begin
               case ($urandom_range(0, 3))
                  0: send_request(CMD_RELEASE, $urandom());
                  1: send_request(CMD_RELEASE, PAGE_W'(base_cfg) - 1);
                  2: send_request(CMD_RELEASE, PAGE_W'(base_cfg) + PAGE_W'(n * WORD_W));
                  default: send_request(CMD_RELEASE, PAGE_W'(base_cfg) +
                                        PAGE_W'($urandom_range(0, n * WORD_W)));
               endcase
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         reply_count++;
         if (pending_replies.size() == 0) begin
            $error("unexpected transfer: status %0d, page_number_res %0h",
                   rsp_status, rsp_page_number_res);
            fail_count++;
         end else begin
            want_reply = pending_replies.pop_front();
            status_count[want_reply.status]++;
            if (rsp_status !== want_reply.status) begin
               $error("status: expected %0d, actual %0d", want_reply.status, rsp_status);
               fail_count++;
            end
            if (rsp_page_number_res !== want_reply.page) begin
               $error("page_number_res: expected %0h, actual %0h",
                      want_reply.page, rsp_page_number_res);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL bitmap_page_allocator");
      $finish;
   end

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_cmd         <= 1'b0;
      req_page_number <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      for (int i = 0; i < MAX_WORDS; i++) used_map[i] = '0;
      hint_idx  = 0;
      base_cfg  = BASE_RESET;
      words_cfg = WORDS_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_exhaustion();
      test_random_traffic();
      wait_idle();
      $display("%0d requests, %0d results: %0d ok, %0d out of memory, %0d invalid, %0d double free",
               sent_count, reply_count, status_count[STAT_OK], status_count[STAT_NOMEM],
               status_count[STAT_INVALID], status_count[STAT_DOUBLE]);
      $display("layouts from 0 to 2047 words, base pages 0 to 0xFFFFFF, sender gaps 0 to 7");
      if (fail_count == 0) begin
         $display("PASS bitmap_page_allocator");
      end else begin
         $display("FAIL bitmap_page_allocator");
      end
      $finish;
   end

endmodule
